FILE: hw/rtl/fixed_block_allocator_refcount_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block allocator
// Shared assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_ALLOCATOR_REFCOUNT_UNIT_MACROS_SVH
`define FIXED_BLOCK_ALLOCATOR_REFCOUNT_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define FBARC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FBARC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fbarc_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block allocator package
// Types, codes and constants shared by the allocator RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbarc_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int ALIGN_LOG2_DEF = 2;

  localparam int REQ_W    = 2;
  localparam int IDX_OUT_W = 8;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 32;
  localparam int FREE_W   = 9;
  localparam int BB_W     = 16;
  localparam int BC_W     = 9;
  localparam int REF_W    = 8;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [REF_W-1:0] REF_LIMIT = 8'd255;

  localparam logic [BB_W-1:0]   BLOCK_BYTES_RST = 16'd64;
  localparam logic [BC_W-1:0]   BLOCK_COUNT_RST = 9'd256;
  localparam logic [ADDR_W-1:0] DATA_BASE_RST   = 32'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_USE   = 2'd2,
    REQ_UNUSE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NONE_FREE  = 3'd1,
    ST_INVALID    = 3'd2,
    ST_IN_USE     = 3'd3,
    ST_NOT_IN_USE = 3'd4,
    ST_TOO_MANY   = 3'd5
  } status_t;

  localparam logic [1:0] REG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] REG_DATA_BASE   = 2'd2;

  typedef struct packed {
    logic [BB_W-1:0]   block_bytes;
    logic [BC_W-1:0]   block_count;
    logic [ADDR_W-1:0] data_base;
    logic              reinit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbarc_ifs.sv
// ----------------------------------------------------------------------------
// Fixed block allocator channels
// Valid/ready interfaces for the request and response items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fbarc_req_if;
  logic                              valid;
  logic                              ready;
  logic [fbarc_pkg::REQ_W-1:0]       req_type;
  logic [fbarc_pkg::IDX_OUT_W-1:0]   block_index;

  modport source (output valid, output req_type, output block_index, input ready);
  modport sink   (input valid, input req_type, input block_index, output ready);
endinterface

interface fbarc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fbarc_pkg::STATUS_W-1:0]    status;
  logic [fbarc_pkg::IDX_OUT_W-1:0]   result_index;
  logic [fbarc_pkg::ADDR_W-1:0]      data_address;
  logic [fbarc_pkg::FREE_W-1:0]      free_blocks;

  modport source (output valid, output status, output result_index,
                  output data_address, output free_blocks, input ready);
  modport sink   (input valid, input status, input result_index,
                  input data_address, input free_blocks, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fbarc_cfg.sv
// ----------------------------------------------------------------------------
// Fixed block allocator register file
// APB-style configuration registers with a reinitialise pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbarc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbarc_pkg::APB_AW-1:0]  paddr,
  input  logic [fbarc_pkg::APB_DW-1:0]  pwdata,
  output logic [fbarc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output fbarc_pkg::cfg_t               cfg
);
  import fbarc_pkg::*;

  logic [BB_W-1:0]   block_bytes;
  logic [BC_W-1:0]   block_count;
  logic [ADDR_W-1:0] data_base;
  logic              reinit;
  logic              wr;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  // The reinit pulse follows a block count write in the cycle after, once the
  // new count is in place; the allocator then resets its allocated flags and free count.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RST;
      block_count <= BLOCK_COUNT_RST;
      data_base   <= DATA_BASE_RST;
      reinit      <= 1'b0;
    end else begin
      reinit <= 1'b0;
      if (wr) begin
        case (reg_idx)
          REG_BLOCK_BYTES: block_bytes <= pwdata[BB_W-1:0];
          REG_BLOCK_COUNT: begin
            block_count <= pwdata[BC_W-1:0];
            reinit      <= 1'b1;
          end
          REG_DATA_BASE:   data_base <= pwdata[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_BYTES: prdata = APB_DW'(block_bytes);
      REG_BLOCK_COUNT: prdata = APB_DW'(block_count);
      REG_DATA_BASE:   prdata = APB_DW'(data_base);
      default:         prdata = '0;
    endcase
  end

  assign cfg.block_bytes = block_bytes;
  assign cfg.block_count = block_count;
  assign cfg.data_base   = data_base;
  assign cfg.reinit      = reinit;

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_block_allocator_refcount_unit.sv
// ----------------------------------------------------------------------------
// Fixed block allocator with reference counts
// Allocates, frees and reference-counts fixed-size blocks; reports addresses.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Carries
//   req      in         valid/ready               req_type, block_index
//   rsp      out        valid/ready               status, result_index,
//                                                 data_address, free_blocks
//   apb      in         psel/penable, pready=1    block_bytes, block_count,
//                                                 data_base
//
// Free, unuse and a failed use pass through the check state; a successful use
// also passes the address state (one multiply, then the base add). A request
// whose index is at or beyond the block count, and an alloc with no free
// block, go straight to the response. Any other alloc scans from the hint,
// one block per cycle, at most the effective block count of blocks.
// Count reads go through a single registered memory port.
// Reset and block count writes clear per-block allocated flags at once; there
// is no clearing pass, and a block count write holds the input off while the
// reinit pulse is high. A stalled response holds the block in its last state
// until the item is taken; one new request may be accepted meanwhile.

`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_allocator_refcount_unit_macros.svh"

module fixed_block_allocator_refcount_unit #(
  parameter int MAX_BLOCKS = fbarc_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_LOG2 = fbarc_pkg::ALIGN_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fbarc_req_if.sink                     req,
  fbarc_rsp_if.source                   rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbarc_pkg::APB_AW-1:0]  paddr,
  input  logic [fbarc_pkg::APB_DW-1:0]  pwdata,
  output logic [fbarc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import fbarc_pkg::*;

  localparam int CAP    = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
  localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int ASZ_W  = BB_W + 1;
  localparam int PROD_W = IDX_W + ASZ_W;
  localparam logic [ASZ_W-1:0] ALIGN_MASK = ASZ_W'((1 << ALIGN_LOG2) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_ADDR,
    S_DONE
  } state_t;

  cfg_t cfg;

  fbarc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t             state;
  logic [CAP-1:0]     occ;
  logic [REF_W-1:0]   mem [CAP];
  logic [REF_W-1:0]   rd_data;
  logic [IDX_W-1:0]   hint;
  logic [CNT_W-1:0]   free_total;
  logic [IDX_W-1:0]   scan_ptr;
  logic [CNT_W-1:0]   scan_k;
  req_t               req_kind;
  logic [IDX_OUT_W-1:0] req_idx;
  logic [PROD_W-1:0]  prod;

  status_t            res_status;
  logic [IDX_OUT_W-1:0] res_idx;
  logic [ADDR_W-1:0]  res_addr;

  logic               rsp_valid;
  status_t            out_status;
  logic [IDX_OUT_W-1:0] out_idx;
  logic [ADDR_W-1:0]  out_addr;
  logic [CNT_W-1:0]   out_free;

  logic [CNT_W-1:0]   eff_n;
  logic [ASZ_W-1:0]   asize;
  logic [CNT_W-1:0]   scan_ptr_p1;
  logic [IDX_W-1:0]   scan_next;
  logic [IDX_W-1:0]   scan_start;
  logic [IDX_W-1:0]   cur_idx;
  logic [REF_W-1:0]   cnt;
  status_t            chk_status;
  logic [REF_W-1:0]   chk_cnt;
  logic               accept;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [REF_W-1:0]   mem_wd;
  logic               scan_hit;
  logic               addr_shown;

  always_comb begin
    if (cfg.block_count == '0) begin
      eff_n = CNT_W'(1);
    end else if (cfg.block_count > BC_W'(CAP)) begin
      eff_n = CNT_W'(CAP);
    end else begin
      eff_n = CNT_W'(cfg.block_count);
    end
  end

  assign asize       = (ASZ_W'(cfg.block_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
  assign scan_ptr_p1 = CNT_W'(scan_ptr) + CNT_W'(1);
  assign scan_next   = (scan_ptr_p1 >= eff_n) ? '0 : scan_ptr_p1[IDX_W-1:0];
  assign scan_start  = (CNT_W'(hint) < eff_n) ? hint : '0;
  assign cur_idx     = req_idx[IDX_W-1:0];
  assign cnt         = occ[cur_idx] ? rd_data : '0;

  assign req.ready = (state == S_IDLE) && !cfg.reinit;
  assign accept    = req.valid && req.ready;

  always_comb begin
    chk_status = ST_OK;
    chk_cnt    = cnt;
    if (cnt == '0) begin
      chk_status = ST_INVALID;
    end else begin
      case (req_kind)
        REQ_FREE: begin
          if (cnt != REF_W'(1)) chk_status = ST_IN_USE;
        end
        REQ_USE: begin
          if (cnt == REF_LIMIT) chk_status = ST_TOO_MANY;
          chk_cnt = cnt + REF_W'(1);
        end
        REQ_UNUSE: begin
          if (cnt == REF_W'(1)) chk_status = ST_NOT_IN_USE;
          chk_cnt = cnt - REF_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = scan_ptr;
    mem_wd = REF_W'(1);
    case (state)
      S_SCAN: mem_we = !occ[scan_ptr];
      S_CHK: begin
        mem_wa = cur_idx;
        mem_wd = chk_cnt;
        mem_we = (chk_status == ST_OK) && (req_kind == REQ_USE || req_kind == REQ_UNUSE);
      end
      default: ;
    endcase
  end

  // Counts are only meaningful where the allocated flag is set.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (accept) rd_data <= mem[req.block_index[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      occ        <= '0;
      hint       <= '0;
      free_total <= CNT_W'(CAP);
    end else begin
      if (rsp_valid && rsp.ready && (state != S_DONE)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind <= req_t'(req.req_type);
            req_idx  <= req.block_index;
            res_idx  <= req.block_index;
            res_addr <= '0;
            if (req_t'(req.req_type) == REQ_ALLOC) begin
              res_idx <= '0;
              if (free_total == '0) begin
                res_status <= ST_NONE_FREE;
                state      <= S_DONE;
              end else begin
                scan_ptr <= scan_start;
                scan_k   <= '0;
                state    <= S_SCAN;
              end
            end else if ({1'b0, req.block_index} >= BC_W'(eff_n)) begin
              res_status <= ST_INVALID;
              state      <= S_DONE;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_SCAN: begin
          if (!occ[scan_ptr]) begin
            occ[scan_ptr] <= 1'b1;
            free_total    <= free_total - CNT_W'(1);
            hint          <= scan_next;
            res_idx       <= IDX_OUT_W'(scan_ptr);
            res_status    <= ST_OK;
            state         <= S_DONE;
          end else if (scan_k + CNT_W'(1) >= eff_n) begin
            res_status <= ST_NONE_FREE;
            state      <= S_DONE;
          end else begin
            scan_ptr <= scan_next;
            scan_k   <= scan_k + CNT_W'(1);
          end
        end
        S_CHK: begin
          res_status <= chk_status;
          state      <= S_DONE;
          if (chk_status == ST_OK) begin
            case (req_kind)
              REQ_FREE: begin
                occ[cur_idx] <= 1'b0;
                hint         <= cur_idx;
                free_total   <= free_total + CNT_W'(1);
              end
              REQ_USE: begin
                prod  <= PROD_W'(cur_idx) * PROD_W'(asize);
                state <= S_ADDR;
              end
              default: ;
            endcase
          end
        end
        S_ADDR: begin
          res_addr <= cfg.data_base + ADDR_W'(prod);
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            out_status <= res_status;
            out_idx    <= res_idx;
            out_addr   <= res_addr;
            out_free   <= free_total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg.reinit) begin
        occ        <= '0;
        hint       <= '0;
        free_total <= eff_n;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_idx;
  assign rsp.data_address = out_addr;
  assign rsp.free_blocks  = FREE_W'(out_free);

  assign scan_hit   = (state == S_SCAN) && !occ[scan_ptr] && !cfg.reinit;
  assign addr_shown = rsp_valid && (out_addr != '0);

  `FBARC_ASSERT(a_free_le_n, (free_total <= eff_n) || cfg.reinit, "free count too high")
  `FBARC_ASSERT(a_hint_in_range, (CNT_W'(hint) < eff_n) || cfg.reinit, "hint out of range")
  `FBARC_ASSERT(a_alloc_marks, scan_hit |=> occ[$past(scan_ptr)], "allocated block not marked")
  `FBARC_ASSERT(a_addr_only_ok, addr_shown |-> (out_status == ST_OK), "address on failed item")
  `FBARC_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE && !rsp_valid), "busy after reset")

endmodule

`default_nettype wire
